// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the GELU activation unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GAU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gelu activation unit: implication check failed");

// The condition must never be seen.
`define GAU_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("gelu activation unit: forbidden condition seen");

`endif

// ===== rtl/gau_pkg.sv =====
// ---------------------------------------------------------------------------
// GELU activation unit package
// Fixed-point constants, the rounding multiply and the sideband word type.
// ---------------------------------------------------------------------------
package gau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QB        = 28;

   localparam logic [28:0] ONE_Q     = 29'd1 << QB;
   localparam logic [31:0] BIG_LIMIT = 32'd8 << FRAC_BITS;

   localparam logic [27:0] LN2_Q = 28'd186065279;
   localparam logic [27:0] K1_Q  = 28'd214180506;
   localparam logic [23:0] K2_Q  = 24'd12003091;
   localparam logic [27:0] RS2_Q = 28'd189812531;
   localparam logic [26:0] PC_Q  = 27'd87937066;
   localparam logic [26:0] A1_Q  = 27'd68405298;
   localparam logic [26:0] A2_Q  = 27'd76369011;
   localparam logic [28:0] A3_Q  = 29'd381557846;
   localparam logic [28:0] A4_Q  = 29'd390077527;
   localparam logic [28:0] A5_Q  = 29'd284918850;

   localparam logic [35:0] EXP_LIMIT = 36'd7442611160;
   localparam logic [8:0]  RECIP_LN2 = 9'd369;

   // Ceiling of 2^32 / k, exact quotient for numerators below 2^28.
   localparam logic [32:0] DIV_RECIP [1:12] = '{
      33'd4294967296, 33'd2147483648, 33'd1431655766, 33'd1073741824,
      33'd858993460,  33'd715827883,  33'd613566757,  33'd536870912,
      33'd477218589,  33'd429496730,  33'd390451573,  33'd357913942
   };

   typedef struct packed {
      logic        last;
      logic        mode;
      logic        negv;
      logic        big;
      logic [23:0] mag;
      logic [28:0] e;
      logic [31:0] den;
   } gau_side_type;

   function automatic logic [43:0] mul_q(input logic [35:0] x, input logic [35:0] y);
      logic [71:0] p;
      p = 72'(x) * 72'(y) + (72'd1 << (QB - 1));
      return p[71:QB];
   endfunction

endpackage

// ===== rtl/gau_exp.sv =====
// ---------------------------------------------------------------------------
// GELU exponential pipeline
// Computes exp(-w) in Q1.28 by range reduction and a twelve-term series.
// ---------------------------------------------------------------------------
module gau_exp import gau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [35:0]  in_w,
   input  gau_side_type in_side,
   output logic         out_valid,
   output logic [28:0]  out_e,
   output gau_side_type out_side
);

   logic         e0_valid_ff, e1_valid_ff;
   gau_side_type e0_side_ff, e1_side_ff;
   logic         e0_zero_ff, e1_zero_ff;
   logic [32:0]  e0_w_ff;
   logic [5:0]   e0_q_ff, e1_q_ff;
   logic [28:0]  e1_r_ff;
   logic [21:0]  qprod;
   logic [33:0]  qln;
   logic [33:0]  r0;
   logic         ge2;

   logic         b_valid_ff [0:12];
   gau_side_type b_side_ff  [0:12];
   logic         b_zero_ff  [0:12];
   logic [5:0]   b_q_ff     [0:12];
   logic [27:0]  b_r_ff     [0:12];
   logic [28:0]  b_term_ff  [0:12];
   logic [28:0]  b_even_ff  [0:12];
   logic [28:0]  b_odd_ff   [0:12];

   logic         a_valid_ff [1:12];
   gau_side_type a_side_ff  [1:12];
   logic         a_zero_ff  [1:12];
   logic [5:0]   a_q_ff     [1:12];
   logic [27:0]  a_r_ff     [1:12];
   logic [27:0]  a_prod_ff  [1:12];
   logic [28:0]  a_even_ff  [1:12];
   logic [28:0]  a_odd_ff   [1:12];

   logic         out_valid_ff;
   logic [28:0]  out_e_ff;
   gau_side_type out_side_ff;
   logic [28:0]  diff;
   logic [28:0]  part;
   logic [29:0]  rnd;
   logic [28:0]  out_e_in;

   assign qprod = 22'(in_w[32:20]) * 22'(RECIP_LN2);

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff <= 1'b0;
         e1_valid_ff <= 1'b0;
         b_valid_ff[0] <= 1'b0;
      end else begin
         e0_valid_ff <= in_valid;
         e1_valid_ff <= e0_valid_ff;
         b_valid_ff[0] <= e1_valid_ff;
      end
      e0_side_ff <= in_side;
      e0_zero_ff <= in_w >= EXP_LIMIT;
      e0_w_ff    <= in_w[32:0];
      e0_q_ff    <= qprod[21:16];
      e1_side_ff <= e0_side_ff;
      e1_zero_ff <= e0_zero_ff;
      e1_q_ff    <= e0_q_ff;
      e1_r_ff    <= r0[28:0];
      b_side_ff[0] <= e1_side_ff;
      b_zero_ff[0] <= e1_zero_ff;
      b_q_ff[0]    <= e1_q_ff + 6'(ge2);
      b_r_ff[0]    <= ge2 ? 28'(e1_r_ff - 29'(LN2_Q)) : e1_r_ff[27:0];
      b_term_ff[0] <= ONE_Q;
      b_even_ff[0] <= ONE_Q;
      b_odd_ff[0]  <= '0;
   end

   assign qln = 34'(e0_q_ff) * 34'(LN2_Q);
   assign r0  = 34'(e0_w_ff) - qln;
   assign ge2 = e1_r_ff >= 29'(LN2_Q);

   for (genvar k = 1; k <= 12; k++) begin : g_term
      logic [43:0] prod_in;
      logic [60:0] dprod;
      logic [28:0] term_in;

      assign prod_in = mul_q(36'(b_term_ff[k-1]), 36'(b_r_ff[k-1]));
      assign dprod   = 61'(a_prod_ff[k]) * 61'(DIV_RECIP[k]);
      assign term_in = dprod[60:32];

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
            b_valid_ff[k] <= 1'b0;
         end else begin
            a_valid_ff[k] <= b_valid_ff[k-1];
            b_valid_ff[k] <= a_valid_ff[k];
         end
         a_side_ff[k] <= b_side_ff[k-1];
         a_zero_ff[k] <= b_zero_ff[k-1];
         a_q_ff[k]    <= b_q_ff[k-1];
         a_r_ff[k]    <= b_r_ff[k-1];
         a_prod_ff[k] <= prod_in[27:0];
         a_even_ff[k] <= b_even_ff[k-1];
         a_odd_ff[k]  <= b_odd_ff[k-1];
         b_side_ff[k] <= a_side_ff[k];
         b_zero_ff[k] <= a_zero_ff[k];
         b_q_ff[k]    <= a_q_ff[k];
         b_r_ff[k]    <= a_r_ff[k];
         b_term_ff[k] <= term_in;
         if (k % 2 == 1) begin
            b_odd_ff[k]  <= a_odd_ff[k] + term_in;
            b_even_ff[k] <= a_even_ff[k];
         end else begin
            b_even_ff[k] <= a_even_ff[k] + term_in;
            b_odd_ff[k]  <= a_odd_ff[k];
         end
      end
   end

   always_comb begin
      diff = (b_even_ff[12] > b_odd_ff[12]) ? b_even_ff[12] - b_odd_ff[12] : '0;
      part = diff >> (b_q_ff[12] - 6'd1);
      rnd  = 30'(part) + 30'd1;
      if (b_zero_ff[12]) begin
         out_e_in = '0;
      end else if (b_q_ff[12] == 6'd0) begin
         out_e_in = diff;
      end else begin
         out_e_in = rnd[29:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= b_valid_ff[12];
      end
      out_e_ff    <= out_e_in;
      out_side_ff <= b_side_ff[12];
   end

   assign out_valid = out_valid_ff;
   assign out_e     = out_e_ff;
   assign out_side  = out_side_ff;

endmodule

// ===== rtl/gau_div.sv =====
// ---------------------------------------------------------------------------
// GELU divider pipeline
// Restoring division, one quotient bit per stage, 29-bit quotient.
// ---------------------------------------------------------------------------
module gau_div import gau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [56:0]  in_num,
   input  logic [31:0]  in_den,
   input  gau_side_type in_side,
   output logic         out_valid,
   output logic [28:0]  out_quo,
   output gau_side_type out_side
);

   logic         d_valid_ff [0:29];
   gau_side_type d_side_ff  [0:29];
   logic [31:0]  d_rem_ff   [0:29];
   logic [28:0]  d_low_ff   [0:29];
   logic [28:0]  d_quo_ff   [0:29];
   logic [31:0]  d_den_ff   [0:29];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else begin
         d_valid_ff[0] <= in_valid;
      end
      d_side_ff[0] <= in_side;
      d_rem_ff[0]  <= 32'(in_num[56:29]);
      d_low_ff[0]  <= in_num[28:0];
      d_quo_ff[0]  <= '0;
      d_den_ff[0]  <= in_den;
   end

   for (genvar i = 1; i <= 29; i++) begin : g_step
      logic [31:0] sh;
      logic        ge;

      assign sh = {d_rem_ff[i-1][30:0], d_low_ff[i-1][28]};
      assign ge = sh >= d_den_ff[i-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[i] <= 1'b0;
         end else begin
            d_valid_ff[i] <= d_valid_ff[i-1];
         end
         d_side_ff[i] <= d_side_ff[i-1];
         d_rem_ff[i]  <= ge ? sh - d_den_ff[i-1] : sh;
         d_low_ff[i]  <= {d_low_ff[i-1][27:0], 1'b0};
         d_quo_ff[i]  <= {d_quo_ff[i-1][27:0], ge};
         d_den_ff[i]  <= d_den_ff[i-1];
      end
   end

   assign out_valid = d_valid_ff[29];
   assign out_quo   = d_quo_ff[29];
   assign out_side  = d_side_ff[29];

endmodule

// ===== rtl/gelu_activation_unit.sv =====
// ---------------------------------------------------------------------------
// GELU activation unit
// Streams signed Q7.16 samples through a fully pipelined GELU, tanh or erf form.
// ---------------------------------------------------------------------------
// Channel   Ports                                    Handshake
// request   start, busy, req_sample, req_last_in     start && !busy
// response  rsp_valid, rsp_activated, rsp_last_out   one-cycle strobe
// control   csr_write_en, csr_write_data             write enable
//
// A word can be taken in every cycle that start is high; busy is always low.
// Each result passes through the 28-stage exponential, the 30-stage divider
// and the polynomial stages around them.
// Reset clears the valid bits of every stage and sets approx_mode to tanh form.
// The receiver cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gelu_activation_unit import gau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_sample,
   input  logic               req_last_in,
   input  logic               csr_write_en,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_activated,
   output logic               rsp_last_out
);

   logic         approx_mode_ff;
   logic         accept;
   logic [23:0]  raw;
   logic [23:0]  mag_in;
   logic         big_in;
   logic [30:0]  a_in;
   gau_side_type side_in;

   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   gau_side_type s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff;
   gau_side_type s3_side_in;
   logic [30:0]  s1_a_ff, s2_a_ff, s3_a_ff, s4_a_ff;
   logic [34:0]  s2_m_ff, s3_m_ff, s4_m_ff;
   logic [35:0]  s5_w_ff;
   logic [43:0]  p2, p3, pc3, p4, p5;
   logic [35:0]  sum5;
   logic [31:0]  den3;
   logic [35:0]  w_in;

   logic         x_valid;
   logic [28:0]  x_e;
   gau_side_type x_side;
   logic [31:0]  tden;
   logic [56:0]  tnum;
   logic [56:0]  enum_num;
   logic [31:0]  div_den;
   logic [56:0]  div_num;
   gau_side_type div_side;

   logic         q_valid;
   logic [28:0]  q_quo;
   gau_side_type q_side;

   logic         b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic         b5_valid_ff, b6_valid_ff, b7_valid_ff;
   gau_side_type b1_side_ff, b2_side_ff, b3_side_ff, b4_side_ff;
   gau_side_type b5_side_ff, b6_side_ff, b7_side_ff;
   logic [28:0]  b1_t_ff, b2_t_ff, b3_t_ff, b4_t_ff, b5_t_ff, b6_t_ff;
   logic [28:0]  b1_tp_ff, b2_tp_ff, b3_tp_ff, b4_tp_ff;
   logic [31:0]  b1_pos_ff, b2_pos_ff, b3_pos_ff, b4_pos_ff, b5_pos_ff;
   logic [31:0]  b2_neg_ff, b3_neg_ff, b4_neg_ff, b5_neg_ff;
   logic [31:0]  b6_tail_ff;
   logic [29:0]  b7_factor_ff;
   logic [43:0]  t2m, a1m, t3m, a2m, t4m, a3m, t5m, a4m, a5m, tailm;
   logic [31:0]  pdiff;
   logic [28:0]  gerf, g_sel, g_in;
   logic [29:0]  factor_in;
   logic [53:0]  fprod;
   logic [24:0]  mraw;
   logic [23:0]  msat;
   logic [23:0]  res_in;

   logic         rsp_valid_ff;
   logic [23:0]  rsp_activated_ff;
   logic         rsp_last_out_ff;
   gau_side_type o_side_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         approx_mode_ff <= 1'b1;
      end else if (csr_write_en) begin
         approx_mode_ff <= csr_write_data;
      end
   end

   always_comb begin
      raw      = req_sample;
      mag_in   = raw[23] ? (~raw + 24'd1) : raw;
      big_in   = 32'(mag_in) >= BIG_LIMIT;
      a_in     = big_in ? '0 : (31'(mag_in) << (QB - FRAC_BITS));
      side_in  = '{last: req_last_in, mode: approx_mode_ff, negv: raw[23], big: big_in,
                   mag: mag_in, e: '0, den: '0};
   end

   assign p2   = mul_q(36'(s1_a_ff), s1_side_ff.mode ? 36'(s1_a_ff) : 36'(RS2_Q));
   assign p3   = mul_q(36'(s2_m_ff), s2_side_ff.mode ? 36'(K2_Q) : 36'(s2_m_ff));
   assign pc3  = mul_q(36'(s2_m_ff), 36'(PC_Q));
   assign den3 = 32'(ONE_Q) + pc3[31:0];
   assign p4   = mul_q(36'(s3_m_ff), 36'(s3_a_ff));
   assign sum5 = 36'(s4_a_ff) + 36'(s4_m_ff);
   assign p5   = mul_q(sum5, 36'(K1_Q));
   assign w_in = s4_side_ff.mode ? {p5[34:0], 1'b0} : 36'(s4_m_ff);

   always_comb begin
      s3_side_in     = s2_side_ff;
      s3_side_in.den = den3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
      s1_side_ff <= side_in;
      s1_a_ff    <= a_in;
      s2_side_ff <= s1_side_ff;
      s2_a_ff    <= s1_a_ff;
      s2_m_ff    <= p2[34:0];
      s3_side_ff <= s3_side_in;
      s3_a_ff    <= s2_a_ff;
      s3_m_ff    <= p3[34:0];
      s4_side_ff <= s3_side_ff;
      s4_a_ff    <= s3_a_ff;
      s4_m_ff    <= s3_side_ff.mode ? p4[34:0] : s3_m_ff;
      s5_side_ff <= s4_side_ff;
      s5_w_ff    <= w_in;
   end

   gau_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_w      (s5_w_ff),
      .in_side   (s5_side_ff),
      .out_valid (x_valid),
      .out_e     (x_e),
      .out_side  (x_side)
   );

   always_comb begin
      tden     = 32'(ONE_Q) + 32'(x_e);
      tnum     = (57'(ONE_Q - x_e) << QB) + 57'(tden >> 1);
      enum_num = (57'd1 << (2 * QB)) + 57'(x_side.den >> 1);
      div_den  = x_side.mode ? tden : x_side.den;
      div_num  = x_side.mode ? tnum : enum_num;
      div_side = x_side;
      div_side.e = x_e;
   end

   gau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (div_side),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_side  (q_side)
   );

   assign t2m   = mul_q(36'(q_quo), 36'(q_quo));
   assign a1m   = mul_q(36'(q_quo), 36'(A1_Q));
   assign t3m   = mul_q(36'(b1_tp_ff), 36'(b1_t_ff));
   assign a2m   = mul_q(36'(b1_tp_ff), 36'(A2_Q));
   assign t4m   = mul_q(36'(b2_tp_ff), 36'(b2_t_ff));
   assign a3m   = mul_q(36'(b2_tp_ff), 36'(A3_Q));
   assign t5m   = mul_q(36'(b3_tp_ff), 36'(b3_t_ff));
   assign a4m   = mul_q(36'(b3_tp_ff), 36'(A4_Q));
   assign a5m   = mul_q(36'(b4_tp_ff), 36'(A5_Q));
   assign pdiff = (b5_pos_ff > b5_neg_ff) ? b5_pos_ff - b5_neg_ff : '0;
   assign tailm = mul_q(36'(pdiff), 36'(b5_side_ff.e));

   always_comb begin
      gerf  = (b6_tail_ff > 32'(ONE_Q)) ? '0 : ONE_Q - b6_tail_ff[28:0];
      g_sel = b6_side_ff.mode ? b6_t_ff : gerf;
      if (b6_side_ff.big || g_sel > ONE_Q) begin
         g_in = ONE_Q;
      end else begin
         g_in = g_sel;
      end
      factor_in = b6_side_ff.negv ? 30'(ONE_Q - g_in) : 30'(ONE_Q) + 30'(g_in);
   end

   always_comb begin
      fprod = 54'(b7_side_ff.mag) * 54'(b7_factor_ff) + (54'd1 << QB);
      mraw  = fprod[53:QB+1];
      if (b7_side_ff.negv) begin
         msat   = (mraw > 25'h800000) ? 24'h800000 : mraw[23:0];
         res_in = 24'd0 - msat;
      end else begin
         msat   = (mraw > 25'h7FFFFF) ? 24'h7FFFFF : mraw[23:0];
         res_in = msat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         b5_valid_ff  <= 1'b0;
         b6_valid_ff  <= 1'b0;
         b7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= q_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         b5_valid_ff  <= b4_valid_ff;
         b6_valid_ff  <= b5_valid_ff;
         b7_valid_ff  <= b6_valid_ff;
         rsp_valid_ff <= b7_valid_ff;
      end
      b1_side_ff <= q_side;
      b1_t_ff    <= q_quo;
      b1_tp_ff   <= t2m[28:0];
      b1_pos_ff  <= a1m[31:0];
      b2_side_ff <= b1_side_ff;
      b2_t_ff    <= b1_t_ff;
      b2_tp_ff   <= t3m[28:0];
      b2_pos_ff  <= b1_pos_ff;
      b2_neg_ff  <= a2m[31:0];
      b3_side_ff <= b2_side_ff;
      b3_t_ff    <= b2_t_ff;
      b3_tp_ff   <= t4m[28:0];
      b3_pos_ff  <= b2_pos_ff + a3m[31:0];
      b3_neg_ff  <= b2_neg_ff;
      b4_side_ff <= b3_side_ff;
      b4_t_ff    <= b3_t_ff;
      b4_tp_ff   <= t5m[28:0];
      b4_pos_ff  <= b3_pos_ff;
      b4_neg_ff  <= b3_neg_ff + a4m[31:0];
      b5_side_ff <= b4_side_ff;
      b5_t_ff    <= b4_t_ff;
      b5_pos_ff  <= b4_pos_ff + a5m[31:0];
      b5_neg_ff  <= b4_neg_ff;
      b6_side_ff <= b5_side_ff;
      b6_t_ff    <= b5_t_ff;
      b6_tail_ff <= tailm[31:0];
      b7_side_ff <= b6_side_ff;
      b7_factor_ff <= factor_in;
      rsp_activated_ff <= res_in;
      rsp_last_out_ff  <= b7_side_ff.last;
      o_side_ff        <= b7_side_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_activated = rsp_activated_ff;
   assign rsp_last_out  = rsp_last_out_ff;

   `GAU_ASSERT_IMPLY(a_exp_range, clock, reset, x_valid, x_e <= ONE_Q)
   `GAU_ASSERT_IMPLY(a_div_range, clock, reset, q_valid, q_quo <= ONE_Q)
   `GAU_ASSERT_IMPLY(a_neg_sign, clock, reset, rsp_valid_ff && o_side_ff.negv, rsp_activated_ff[23] || rsp_activated_ff == '0)
   `GAU_ASSERT_IMPLY(a_big_pass, clock, reset, rsp_valid_ff && o_side_ff.big && !o_side_ff.negv, rsp_activated_ff == o_side_ff.mag)
   `GAU_ASSERT_NEVER(a_big_neg_zero, clock, reset, rsp_valid_ff && o_side_ff.big && o_side_ff.negv && rsp_activated_ff != '0)

endmodule

// ===== bench/gelu_activation_checker.sv =====
// ---------------------------------------------------------------------------
// GELU activation checker
// Watches the request, response and control ports of the GELU activation
// unit. It predicts each result in bit-exact fixed point and compares every
// response word with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module gelu_activation_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [23:0] req_sample,
   input  logic               req_last_in,
   input  logic               csr_write_en,
   input  logic               csr_write_data,
   input  logic               rsp_valid,
   input  logic signed [23:0] rsp_activated,
   input  logic               rsp_last_out,
   output int                 fail_count,
   output int                 pending
);

   typedef logic [63:0] u64_type;

   typedef struct packed {
      logic [23:0] activated;
      logic        last;
      logic [23:0] sample;
   } gelu_word_type;

   localparam u64_type ONE   = 64'd1 << 28;
   localparam u64_type HALFQ = 64'd1 << 27;
   localparam u64_type LN2   = 64'd186065279;
   localparam u64_type K1    = 64'd214180506;
   localparam u64_type K2    = 64'd12003091;
   localparam u64_type RS2   = 64'd189812531;
   localparam u64_type PC    = 64'd87937066;
   localparam u64_type A1    = 64'd68405298;
   localparam u64_type A2    = 64'd76369011;
   localparam u64_type A3    = 64'd381557846;
   localparam u64_type A4    = 64'd390077527;
   localparam u64_type A5    = 64'd284918850;
   localparam u64_type SIGNB = 64'h800000;

   logic          tanh_mode;
   gelu_word_type expected_words[$];

   function automatic u64_type qmul(input u64_type x, input u64_type y);
      return (x * y + HALFQ) >> 28;
   endfunction

   function automatic u64_type exp_decay(input u64_type w);
      u64_type q, r, term, even, odd, res;
      q = w / LN2;
      r = w - q * LN2;
      term = ONE;
      even = ONE;
      odd = 0;
      if (q >= 40) return 0;
      for (int k = 1; k <= 12; k++) begin
         term = qmul(term, r) / u64_type'(k);
         if (k % 2 == 1) odd += term;
         else even += term;
      end
      res = (even > odd) ? even - odd : 0;
      if (q > 0) res = (res + (64'd1 << (q - 1))) >> q;
      return res;
   endfunction

   function automatic u64_type tanh_shape(input u64_type a);
      u64_type a2, u, z, e, d;
      a2 = qmul(a, a);
      u = qmul(qmul(K2, a2), a);
      z = qmul(K1, a + u);
      e = exp_decay(2 * z);
      d = ONE + e;
      return (((ONE - e) << 28) + d / 2) / d;
   endfunction

   function automatic u64_type erf_shape(input u64_type a);
      u64_type x, e, d, t, t2, t3, t4, t5, pos, neg, p, tail;
      x = qmul(a, RS2);
      e = exp_decay(qmul(x, x));
      d = ONE + qmul(PC, x);
      t = ((64'd1 << 56) + d / 2) / d;
      t2 = qmul(t, t);
      t3 = qmul(t2, t);
      t4 = qmul(t3, t);
      t5 = qmul(t4, t);
      pos = qmul(A1, t) + qmul(A3, t3) + qmul(A5, t5);
      neg = qmul(A2, t2) + qmul(A4, t4);
      p = (pos > neg) ? pos - neg : 0;
      tail = qmul(p, e);
      if (tail > ONE) tail = ONE;
      return ONE - tail;
   endfunction

   function automatic logic [23:0] gelu_of(input logic [23:0] v, input logic use_tanh);
      logic negv;
      u64_type mag, g, factor, m;
      negv = v[23];
      mag = negv ? (64'h1000000 - u64_type'(v)) : u64_type'(v);
      if (mag >= (64'd8 << 16)) g = ONE;
      else if (use_tanh) g = tanh_shape(mag << 12);
      else g = erf_shape(mag << 12);
      if (g > ONE) g = ONE;
      factor = negv ? (ONE - g) : (ONE + g);
      m = (mag * factor + ONE) >> 29;
      if (negv) begin
         if (m > SIGNB) m = SIGNB;
         return 24'(64'd0 - m);
      end
      if (m > SIGNB - 1) m = SIGNB - 1;
      return 24'(m);
   endfunction

   assign pending = expected_words.size();

   always @(posedge clock) begin
      gelu_word_type w;
      if (reset) begin
         tanh_mode <= 1'b1;
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_en) tanh_mode <= csr_write_data;
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected response word: activated=%0d last=%0b",
                           rsp_activated, rsp_last_out);
               fail_count <= fail_count + 1;
            end else begin
               w = expected_words.pop_front();
               if (w.activated !== rsp_activated || w.last !== rsp_last_out) begin
                  if (fail_count < 10)
                     $display("Mismatch for sample %0d: expected %0d/%0b, got %0d/%0b",
                              $signed(w.sample), $signed(w.activated), w.last,
                              rsp_activated, rsp_last_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            w.sample = req_sample;
            w.last = req_last_in;
            w.activated = gelu_of(req_sample, tanh_mode);
            expected_words.insert(expected_words.size(), w);
         end
      end
   end

endmodule

// ===== bench/gelu_activation_unit_tb.sv =====
// ---------------------------------------------------------------------------
// GELU activation unit testbench
// Drives directed and random samples through both GELU forms, with random
// gaps between words and mode changes while the pipeline is empty. The
// checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module gelu_activation_unit_tb;
   import gau_pkg::*;

   localparam int LATENCY = 71;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [23:0] req_sample;
   logic               req_last_in;
   logic               csr_write_en;
   logic               csr_write_data;
   logic               rsp_valid;
   logic signed [23:0] rsp_activated;
   logic               rsp_last_out;
   int                 fail_count;
   int                 pending;

   gelu_activation_unit dut (.*);

   gelu_activation_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_word(input logic [23:0] v, input logic last);
      int gap;
      start <= 1'b1;
      req_sample <= v;
      req_last_in <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: gap = 0;
         5, 6, 7: gap = $urandom_range(1, 3);
         8: gap = $urandom_range(4, 12);
         default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : 0;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_write_en <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_directed;
      logic [23:0] edge_values [$];
      edge_values = '{24'sd0, 24'sd1, -24'sd1, 24'h7FFFFF, 24'h800000, 24'sd524288,
                      24'sd524287, -24'sd524288, -24'sd524287, 24'sd65536, -24'sd65536,
                      24'sd32768, -24'sd32768, 24'sd196608, -24'sd196608, 24'sd6553600,
                      -24'sd6553600, 24'h555555, 24'hAAAAAA, 24'sd100};
      foreach (edge_values[i]) send_word(edge_values[i], i[0]);
   endtask

   task automatic send_random(input int count);
      logic [23:0] v;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1: v = 24'($urandom);
            2: v = 24'($signed($urandom_range(0, 2097152)) - 1048576);
            default: v = 24'($signed($urandom_range(0, 1048574)) - 524287);
         endcase
         send_word(v, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_sample = '0;
      req_last_in = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      send_random(200);
      drain_pipeline();
      write_mode(1'b0);
      send_directed();
      send_random(200);
      drain_pipeline();
      write_mode(1'b1);
      send_random(105);
      drain_pipeline();
      write_mode(1'b0);
      send_random(105);
      drain_pipeline();

      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gau_pkg.sv
rtl/gau_exp.sv
rtl/gau_div.sv
rtl/gelu_activation_unit.sv
bench/gelu_activation_checker.sv
bench/gelu_activation_unit_tb.sv
